// ----- hdl/bpsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpsa_pkg
// Shared types, codes and helpers of the bitmap pool slot allocator.
// ----------------------------------------------------------------------------
package bpsa_pkg;

  localparam int NumPoolsDef  = 8;
  localparam int SlotsPerPool = 32;
  localparam int PoolW        = 3;
  localparam int SlotW        = 5;
  localparam int SizeW        = 16;
  localparam int OffsW        = 21;
  localparam int StatusW      = 2;
  localparam logic [SizeW-1:0] ItemSizeRst = 16'd16;

  typedef logic [SlotsPerPool-1:0] bits_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 2'd0,
    ST_NO_POOL  = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    L_NONE,
    L_PUSH_FRONT,
    L_ROTATE,
    L_REMOVE,
    L_TO_FRONT
  } list_op_t;

  typedef struct packed {
    list_op_t         op;
    logic [PoolW-1:0] pool;
  } list_cmd_t;

  // lowest set bit, 31 when none is set
  function automatic logic [SlotW-1:0] lowest_set(input bits_t v);
    logic [SlotW-1:0] n;
    n = SlotW'(SlotsPerPool - 1);
    for (int i = SlotsPerPool - 1; i >= 0; i--) begin
      if (v[i]) n = SlotW'(i);
    end
    return n;
  endfunction

endpackage

// ----- hdl/bpsa_list.sv -----
// ----------------------------------------------------------------------------
// bpsa_list
// Order list of live pools, front first, with its fill count.
// ----------------------------------------------------------------------------
module bpsa_list #(
  parameter int NUM_POOLS = bpsa_pkg::NumPoolsDef
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bpsa_pkg::list_cmd_t               cmd,
  output logic [bpsa_pkg::PoolW-1:0]        front,
  output logic [$clog2(NUM_POOLS+1)-1:0]    count
);
  localparam int CW = $clog2(NUM_POOLS + 1);

  logic [bpsa_pkg::PoolW-1:0] list      [NUM_POOLS];
  logic [bpsa_pkg::PoolW-1:0] list_next [NUM_POOLS];
  logic [CW-1:0]              count_next;
  logic [NUM_POOLS-1:0]       hit;
  logic [NUM_POOLS-1:0]       upto;

  assign front = list[0];

  always_comb begin
    for (int i = 0; i < NUM_POOLS; i++) begin
      hit[i] = (CW'(i) < count) && (list[i] == cmd.pool);
    end
    upto[0] = hit[0];
    for (int i = 1; i < NUM_POOLS; i++) begin
      upto[i] = upto[i-1] | hit[i];
    end
  end

  always_comb begin
    list_next  = list;
    count_next = count;
    case (cmd.op)
      bpsa_pkg::L_PUSH_FRONT: begin
        for (int i = 1; i < NUM_POOLS; i++) list_next[i] = list[i-1];
        list_next[0] = cmd.pool;
        count_next   = count + CW'(1);
      end
      bpsa_pkg::L_ROTATE: begin
        for (int i = 0; i < NUM_POOLS; i++) begin
          if (CW'(i) == count - CW'(1)) begin
            list_next[i] = list[0];
          end else if (CW'(i) < count - CW'(1)) begin
            list_next[i] = list[(i + 1) % NUM_POOLS];
          end
        end
      end
      bpsa_pkg::L_REMOVE: begin
        for (int i = 0; i + 1 < NUM_POOLS; i++) begin
          if (upto[i]) list_next[i] = list[i+1];
        end
        if (upto[NUM_POOLS-1]) count_next = count - CW'(1);
      end
      bpsa_pkg::L_TO_FRONT: begin
        for (int i = 1; i < NUM_POOLS; i++) begin
          if (!upto[i-1]) list_next[i] = list[i-1];
        end
        list_next[0] = cmd.pool;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    list <= list_next;
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ----- hdl/bitmap_pool_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_pool_slot_allocator
// Slot allocator over pools of 32 slots with per-pool free bitmaps.
// ----------------------------------------------------------------------------
// For each item, the pool's free bitmap is read from a synchronous memory
// in the cycle the item is accepted, then modified and written back in
// S_EXEC, with the order list and result updated then. in_stall is high
// while in S_EXEC, which is left only once the result register is empty
// or not stalled. A result waiting in the output register does not block
// the next item's bitmap read. NUM_POOLS may be 1 to 8, since pool numbers
// are three bits wide.
module bitmap_pool_slot_allocator #(
  parameter int NUM_POOLS = bpsa_pkg::NumPoolsDef
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [bpsa_pkg::PoolW-1:0]        pool_index,
  input  logic [bpsa_pkg::SlotW-1:0]        slot_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bpsa_pkg::StatusW-1:0]      status,
  output logic [bpsa_pkg::PoolW-1:0]        out_pool,
  output logic [bpsa_pkg::SlotW-1:0]        out_slot,
  output logic [bpsa_pkg::OffsW-1:0]        byte_offset,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpsa_pkg::SizeW-1:0]        slot_bytes
);
  localparam int AW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int CW = $clog2(NUM_POOLS + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                       state;
  logic [bpsa_pkg::SizeW-1:0]   size_reg;
  logic                         op_reg;
  logic [bpsa_pkg::PoolW-1:0]   pidx_reg;
  logic [bpsa_pkg::SlotW-1:0]   sidx_reg;
  logic [NUM_POOLS-1:0]         pool_live;
  logic [NUM_POOLS-1:0]         pool_live_next;

  bpsa_pkg::bits_t              mem [NUM_POOLS];
  bpsa_pkg::bits_t              rdata;
  logic [AW-1:0]                raddr;
  logic                         we;
  logic [AW-1:0]                waddr;
  bpsa_pkg::bits_t              wdata;

  bpsa_pkg::list_cmd_t          lcmd;
  logic [bpsa_pkg::PoolW-1:0]   front;
  logic [CW-1:0]                count;

  logic                         accept;
  logic                         go;
  logic                         have_front;
  logic                         found;
  logic [bpsa_pkg::PoolW-1:0]   free_idx;
  logic [bpsa_pkg::PoolW-1:0]   pool_sel;
  bpsa_pkg::bits_t              bits;
  bpsa_pkg::bits_t              nb;
  bpsa_pkg::bits_t              nbf;
  logic [bpsa_pkg::SlotW-1:0]   s;
  logic                         live_ok;
  bpsa_pkg::status_t            status_next;
  logic [bpsa_pkg::PoolW-1:0]   pool_next;
  logic [bpsa_pkg::SlotW-1:0]   slot_next;
  logic [bpsa_pkg::OffsW-1:0]   offs_next;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign go        = (state == S_EXEC) && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;

  assign raddr = (op == bpsa_pkg::OP_FREE) ? pool_index[AW-1:0] : front[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (accept) rdata <= mem[raddr];
  end

  bpsa_list #(.NUM_POOLS(NUM_POOLS)) u_list (
    .clk   (clk),
    .rst   (rst),
    .cmd   (lcmd),
    .front (front),
    .count (count)
  );

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int p = NUM_POOLS - 1; p >= 0; p--) begin
      if (!pool_live[p]) begin
        found    = 1'b1;
        free_idx = bpsa_pkg::PoolW'(p);
      end
    end
  end

  always_comb begin
    have_front = (count != '0) && (rdata != '0);
    pool_sel   = have_front ? front : free_idx;
    bits       = have_front ? rdata : '1;
    s          = bpsa_pkg::lowest_set(bits);
    nb         = bits & ~(bpsa_pkg::bits_t'(1) << s);
    nbf        = rdata | (bpsa_pkg::bits_t'(1) << sidx_reg);
    live_ok    = (int'(pidx_reg) < NUM_POOLS) && pool_live[pidx_reg[AW-1:0]];

    pool_live_next = pool_live;
    lcmd.op        = bpsa_pkg::L_NONE;
    lcmd.pool      = pool_sel;
    we             = 1'b0;
    waddr          = pool_sel[AW-1:0];
    wdata          = nb;
    status_next    = bpsa_pkg::ST_DONE;
    pool_next      = '0;
    slot_next      = '0;
    offs_next      = '0;

    if (op_reg == bpsa_pkg::OP_ALLOC) begin
      if (have_front || found) begin
        we        = 1'b1;
        pool_next = pool_sel;
        slot_next = s;
        offs_next = bpsa_pkg::OffsW'(s) * bpsa_pkg::OffsW'(size_reg);
        if (!have_front) begin
          lcmd.op = bpsa_pkg::L_PUSH_FRONT;
          pool_live_next[free_idx[AW-1:0]] = 1'b1;
        end else if (nb == '0) begin
          lcmd.op = bpsa_pkg::L_ROTATE;
        end
      end else begin
        status_next = bpsa_pkg::ST_NO_POOL;
      end
    end else begin
      lcmd.pool = pidx_reg;
      waddr     = pidx_reg[AW-1:0];
      wdata     = nbf;
      if (!live_ok) begin
        status_next = bpsa_pkg::ST_NOT_LIVE;
      end else begin
        we = 1'b1;
        if (nbf == '1) begin
          lcmd.op = bpsa_pkg::L_REMOVE;
          pool_live_next[pidx_reg[AW-1:0]] = 1'b0;
        end else if (rdata != '1) begin
          lcmd.op = bpsa_pkg::L_TO_FRONT;
        end
      end
    end

    if (!go) begin
      we      = 1'b0;
      lcmd.op = bpsa_pkg::L_NONE;
      pool_live_next = pool_live;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg   <= op;
      pidx_reg <= pool_index;
      sidx_reg <= slot_index;
    end
    if (go) begin
      status      <= status_next;
      out_pool    <= pool_next;
      out_slot    <= slot_next;
      byte_offset <= offs_next;
    end
    if (rst) begin
      state     <= S_IDLE;
      pool_live <= '0;
      out_valid <= 1'b0;
      size_reg  <= bpsa_pkg::ItemSizeRst;
    end else begin
      pool_live <= pool_live_next;
      if (cfg_valid && cfg_ready) size_reg <= slot_bytes;
      case (state)
        S_IDLE:  if (accept) state <= S_EXEC;
        S_EXEC:  if (go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    int'(count) == $countones(pool_live))
    else $error("list count differs from live pools");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted item not executed");

  a_fail_no_pool: assert property (@(posedge clk) disable iff (rst)
    go && status_next == bpsa_pkg::ST_NO_POOL |-> pool_live == '1)
    else $error("allocate failed with a pool free");

endmodule
